### sv/mrxp_pkg.sv
// ----------------------------------------------------------------------------
// mrxp_pkg: shared types, constants and microcode for the exchange schedule
// Widths, configuration register indexes, radix helpers and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package mrxp_pkg;

	// field widths
	localparam int RANK_W    = 16;
	localparam int RPB_W     = 17;
	localparam int STAGE_W   = 5;
	localparam int WIDTH_W   = 3;
	localparam int TOTAL_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int DIVCNT_W  = 4;

	localparam logic [STAGE_W-1:0]  MAX_STAGES = 5'd20;
	localparam logic [DIVCNT_W-1:0] DIV_LAST   = DIVCNT_W'(RANK_W - 1);

	// reciprocals for exact 16-bit division by 3 and by 5
	localparam logic [RPB_W-1:0] RECIP3 = 17'd43691;  // (2^17 + 1) / 3
	localparam logic [RPB_W-1:0] RECIP5 = 17'd52429;  // (2^18 + 1) / 5

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANKS_PER_BOARD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTER_R2        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTER_R3        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTER_R5        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTRA_R2        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INTRA_R3        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INTRA_R5        = 3'd6;

	// radix phases
	localparam logic [1:0] PH_R2 = 2'd0;
	localparam logic [1:0] PH_R3 = 2'd1;
	localparam logic [1:0] PH_R5 = 2'd2;

	localparam logic [WIDTH_W-1:0] RADIX2 = 3'd2;
	localparam logic [WIDTH_W-1:0] RADIX3 = 3'd3;
	localparam logic [WIDTH_W-1:0] RADIX5 = 3'd5;

	// datapath operation of one microcode step
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,   // take a rank, prime the divider
		ACT_DIV,    // one restoring division step
		ACT_INIT,   // start the inter-board walk
		ACT_DIGIT,  // quotient of the running digit source by the radix
		ACT_BASE,   // extract digit, form rank with that digit cleared
		ACT_EMIT,   // load one stage result
		ACT_NEXT,   // advance radix phase or level
		ACT_EMPTY   // load the no-stage result
	} act_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_DIV_BUSY,
		COND_TOTAL_ZERO,
		COND_REP_DONE,
		COND_OUT_BUSY,
		COND_NOT_DONE
	} cond_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} uc_word_t;

	// step addresses
	localparam upc_t UPC_IDLE  = 4'd0;
	localparam upc_t UPC_DIV   = 4'd1;
	localparam upc_t UPC_INIT  = 4'd2;
	localparam upc_t UPC_CHK   = 4'd3;
	localparam upc_t UPC_BASE  = 4'd4;
	localparam upc_t UPC_EMIT  = 4'd5;
	localparam upc_t UPC_LOOP  = 4'd6;
	localparam upc_t UPC_DONE  = 4'd7;
	localparam upc_t UPC_NEXT  = 4'd8;
	localparam upc_t UPC_EMPTY = 4'd9;
	localparam upc_t UPC_FIN   = 4'd10;

	// control store: jump to target when the condition holds, else fall through
	function automatic uc_word_t uc_rom(input upc_t pc);
		uc_word_t w;
		unique case (pc)
			UPC_IDLE:  w = '{act: ACT_LOAD,  cond: COND_NO_INPUT,   target: UPC_IDLE};
			UPC_DIV:   w = '{act: ACT_DIV,   cond: COND_DIV_BUSY,   target: UPC_DIV};
			UPC_INIT:  w = '{act: ACT_INIT,  cond: COND_TOTAL_ZERO, target: UPC_EMPTY};
			UPC_CHK:   w = '{act: ACT_DIGIT, cond: COND_REP_DONE,   target: UPC_NEXT};
			UPC_BASE:  w = '{act: ACT_BASE,  cond: COND_NEVER,      target: UPC_IDLE};
			UPC_EMIT:  w = '{act: ACT_EMIT,  cond: COND_OUT_BUSY,   target: UPC_EMIT};
			UPC_LOOP:  w = '{act: ACT_NONE,  cond: COND_NOT_DONE,   target: UPC_CHK};
			UPC_DONE:  w = '{act: ACT_NONE,  cond: COND_ALWAYS,     target: UPC_IDLE};
			UPC_NEXT:  w = '{act: ACT_NEXT,  cond: COND_ALWAYS,     target: UPC_CHK};
			UPC_EMPTY: w = '{act: ACT_EMPTY, cond: COND_OUT_BUSY,   target: UPC_EMPTY};
			UPC_FIN:   w = '{act: ACT_NONE,  cond: COND_ALWAYS,     target: UPC_IDLE};
			default:   w = '{act: ACT_NONE,  cond: COND_ALWAYS,     target: UPC_IDLE};
		endcase
		return w;
	endfunction

	// radix of a phase
	function automatic logic [WIDTH_W-1:0] radix_of(input logic [1:0] ph);
		logic [WIDTH_W-1:0] r;
		unique case (ph)
			PH_R2:   r = RADIX2;
			PH_R3:   r = RADIX3;
			PH_R5:   r = RADIX5;
			default: r = RADIX2;
		endcase
		return r;
	endfunction

	// v * r modulo 2^16 by shift and add
	function automatic logic [RANK_W-1:0] mul_radix(input logic [RANK_W-1:0] v,
			input logic [1:0] ph);
		logic [RANK_W-1:0] m;
		unique case (ph)
			PH_R2:   m = v << 1;
			PH_R3:   m = (v << 1) + v;
			PH_R5:   m = (v << 2) + v;
			default: m = v << 1;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### sv/mixed_radix_exchange_partners.sv
// ----------------------------------------------------------------------------
// mixed_radix_exchange_partners: partner ranks of a mixed-radix exchange
// A new rank is taken only while the sequencer is idle, after the last result of the
//   previous rank has been loaded into the output register; the rank passes the
//   bit-serial rank / board-size divider before the first result is registered.
// Reset: asynchronous, sequencer idle, output empty, board size 1, counts 0.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_exchange_partners
	import mrxp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// rank channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [RANK_W-1:0]    node_rank,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [STAGE_W-1:0]        stage_number,
	output logic [WIDTH_W-1:0]        group_width,
	output logic [RANK_W-1:0]         partner_zero,
	output logic [RANK_W-1:0]         partner_one,
	output logic [RANK_W-1:0]         partner_two,
	output logic [RANK_W-1:0]         partner_three,
	output logic [RANK_W-1:0]         partner_four,
	output logic                      final_stage,
	output logic                      truncated,
	// configuration writes
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [RPB_W-1:0]     wr_data
);

	// configuration registers
	logic [RPB_W-1:0] rpb_q;
	logic [4:0]       inter2_q, intra2_q;
	logic [3:0]       inter3_q, intra3_q;
	logic [2:0]       inter5_q, intra5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpb_q    <= RPB_W'(1);
			inter2_q <= '0;
			inter3_q <= '0;
			inter5_q <= '0;
			intra2_q <= '0;
			intra3_q <= '0;
			intra5_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_RANKS_PER_BOARD: rpb_q    <= wr_data;
				CFG_INTER_R2:        inter2_q <= wr_data[4:0];
				CFG_INTER_R3:        inter3_q <= wr_data[3:0];
				CFG_INTER_R5:        inter5_q <= wr_data[2:0];
				CFG_INTRA_R2:        intra2_q <= wr_data[4:0];
				CFG_INTRA_R3:        intra3_q <= wr_data[3:0];
				CFG_INTRA_R5:        intra5_q <= wr_data[2:0];
				default:             ;
			endcase
		end
	end

	// derived configuration: board size (zero acts as one), stage total, limit
	logic [RPB_W-1:0]   rpb_eff;
	logic [TOTAL_W-1:0] total;
	logic               trunc;
	logic [STAGE_W-1:0] limit;

	assign rpb_eff = (rpb_q == '0) ? RPB_W'(1) : rpb_q;
	assign total   = TOTAL_W'(inter2_q) + TOTAL_W'(inter3_q) + TOTAL_W'(inter5_q)
		+ TOTAL_W'(intra2_q) + TOTAL_W'(intra3_q) + TOTAL_W'(intra5_q);
	assign trunc   = total > TOTAL_W'(MAX_STAGES);
	assign limit   = trunc ? MAX_STAGES : total[STAGE_W-1:0];

	// sequencer
	upc_t     upc_q, upc_d;
	uc_word_t uw;
	logic     cond_true;

	// datapath registers
	logic [RANK_W-1:0]   rank_q;
	logic [RANK_W-1:0]   high_q;      // divider quotient, then running digit source
	logic [RANK_W-1:0]   rem_q;       // divider remainder = board offset
	logic [DIVCNT_W-1:0] div_cnt_q;
	logic [RANK_W-1:0]   q_q;         // high_q / radix
	logic [RANK_W-1:0]   base_q;      // rank with the stage digit set to 0
	logic [RANK_W-1:0]   step_q;      // rank change for one unit of the stage digit
	logic                level_q;     // 0 inter-board, 1 intra-board
	logic [1:0]          phase_q;
	logic [4:0]          rep_q;
	logic [STAGE_W-1:0]  stage_q;

	// output register
	logic                out_valid_q;
	logic [STAGE_W-1:0]  stage_number_q;
	logic [WIDTH_W-1:0]  group_width_q;
	logic [RANK_W-1:0]   p0_q, p1_q, p2_q, p3_q, p4_q;
	logic                final_q, trunc_q;
	logic                out_free;

	assign uw       = uc_rom(upc_q);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (uw.act == ACT_LOAD);

	// stage count of the current level and phase
	logic [4:0]         cnt_sel;
	logic [WIDTH_W-1:0] radix;

	always_comb begin
		unique case ({level_q, phase_q})
			{1'b0, PH_R2}: cnt_sel = inter2_q;
			{1'b0, PH_R3}: cnt_sel = 5'(inter3_q);
			{1'b0, PH_R5}: cnt_sel = 5'(inter5_q);
			{1'b1, PH_R2}: cnt_sel = intra2_q;
			{1'b1, PH_R3}: cnt_sel = 5'(intra3_q);
			{1'b1, PH_R5}: cnt_sel = 5'(intra5_q);
			default:       cnt_sel = '0;
		endcase
	end

	assign radix = radix_of(phase_q);

	// next step address
	always_comb begin
		unique case (uw.cond)
			COND_NEVER:      cond_true = 1'b0;
			COND_ALWAYS:     cond_true = 1'b1;
			COND_NO_INPUT:   cond_true = !in_valid;
			COND_DIV_BUSY:   cond_true = (div_cnt_q != DIV_LAST);
			COND_TOTAL_ZERO: cond_true = (total == '0);
			COND_REP_DONE:   cond_true = (rep_q == cnt_sel);
			COND_OUT_BUSY:   cond_true = !out_free;
			COND_NOT_DONE:   cond_true = (stage_q != limit);
			default:         cond_true = 1'b0;
		endcase
		upc_d = cond_true ? uw.target : upc_t'(upc_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	// restoring divider step
	logic [RANK_W:0] trial;
	logic            trial_ge;

	assign trial    = {rem_q, high_q[RANK_W-1]};
	assign trial_ge = (trial >= rpb_eff);

	// quotient by the radix through a reciprocal multiply
	logic [RPB_W-1:0]      recip;
	logic [RANK_W+RPB_W-1:0] recip_prod;
	logic [RANK_W-1:0]     quot;

	always_comb begin
		recip      = (phase_q == PH_R3) ? RECIP3 : RECIP5;
		recip_prod = high_q * recip;
		unique case (phase_q)
			PH_R2:   quot = high_q >> 1;
			PH_R3:   quot = recip_prod[RANK_W+RPB_W-1:RPB_W];
			PH_R5:   quot = RANK_W'(recip_prod[RANK_W+RPB_W-1:RPB_W+1]);
			default: quot = high_q >> 1;
		endcase
	end

	// stage digit and the rank with that digit cleared
	logic [RANK_W-1:0] digit_full;
	logic [2:0]        digit;
	logic [RANK_W-1:0] digit_step;

	assign digit_full = high_q - mul_radix(q_q, phase_q);
	assign digit      = digit_full[2:0];

	always_comb begin
		unique case (digit)
			3'd0:    digit_step = '0;
			3'd1:    digit_step = step_q;
			3'd2:    digit_step = step_q << 1;
			3'd3:    digit_step = (step_q << 1) + step_q;
			3'd4:    digit_step = step_q << 2;
			default: digit_step = '0;
		endcase
	end

	// partner ranks: base plus digit value times step
	logic [RANK_W-1:0] step2, pr1, pr2, pr3, pr4;
	logic              last_stage;

	assign step2      = step_q << 1;
	assign pr1        = base_q + step_q;
	assign pr2        = base_q + step2;
	assign pr3        = pr2 + step_q;
	assign pr4        = pr2 + step2;
	assign last_stage = (STAGE_W'(stage_q + 1'b1) == limit);

	// datapath
	always_ff @(posedge clk) begin
		unique case (uw.act)
			ACT_LOAD: begin
				if (in_valid) begin
					rank_q    <= node_rank;
					high_q    <= node_rank;
					rem_q     <= '0;
					div_cnt_q <= '0;
				end
			end
			ACT_DIV: begin
				rem_q     <= trial_ge ? RANK_W'(trial - rpb_eff) : trial[RANK_W-1:0];
				high_q    <= {high_q[RANK_W-2:0], trial_ge};
				div_cnt_q <= DIVCNT_W'(div_cnt_q + 1'b1);
			end
			ACT_INIT: begin
				level_q <= 1'b0;
				phase_q <= PH_R2;
				rep_q   <= '0;
				stage_q <= '0;
				step_q  <= rpb_eff[RANK_W-1:0];
			end
			ACT_DIGIT: begin
				q_q <= quot;
			end
			ACT_BASE: begin
				base_q <= rank_q - digit_step;
			end
			ACT_EMIT: begin
				if (out_free) begin
					high_q  <= q_q;
					step_q  <= mul_radix(step_q, phase_q);
					rep_q   <= 5'(rep_q + 1'b1);
					stage_q <= STAGE_W'(stage_q + 1'b1);
				end
			end
			ACT_NEXT: begin
				rep_q <= '0;
				if (phase_q == PH_R5) begin
					phase_q <= PH_R2;
					level_q <= 1'b1;
					high_q  <= rem_q;
					step_q  <= RANK_W'(1);
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((uw.act == ACT_EMIT || uw.act == ACT_EMPTY) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (uw.act == ACT_EMIT && out_free) begin
			stage_number_q <= stage_q;
			group_width_q  <= radix;
			p0_q           <= base_q;
			p1_q           <= pr1;
			p2_q           <= (radix == RADIX2) ? '0 : pr2;
			p3_q           <= (radix == RADIX5) ? pr3 : '0;
			p4_q           <= (radix == RADIX5) ? pr4 : '0;
			final_q        <= last_stage;
			trunc_q        <= trunc;
		end else if (uw.act == ACT_EMPTY && out_free) begin
			stage_number_q <= '0;
			group_width_q  <= '0;
			p0_q           <= '0;
			p1_q           <= '0;
			p2_q           <= '0;
			p3_q           <= '0;
			p4_q           <= '0;
			final_q        <= 1'b1;
			trunc_q        <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign stage_number  = stage_number_q;
	assign group_width   = group_width_q;
	assign partner_zero  = p0_q;
	assign partner_one   = p1_q;
	assign partner_two   = p2_q;
	assign partner_three = p3_q;
	assign partner_four  = p4_q;
	assign final_stage   = final_q;
	assign truncated     = trunc_q;

	// checks
	// a stage is only started while below the limit
	a_stage_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_CHK) |-> (stage_q < limit))
		else $error("stage counter reached limit inside the stage loop");

	// repeat counter never passes the phase count
	a_rep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_CHK) |-> (rep_q <= cnt_sel))
		else $error("phase repeat counter overran its count");

	// the quotient by the radix leaves a digit below the radix
	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_BASE) |-> (digit_full < RANK_W'(radix)))
		else $error("stage digit not below the radix");

	// the final result of a rank sends the sequencer back toward idle
	a_final_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		((uw.act == ACT_EMIT) && out_free && last_stage) |=> (upc_q == UPC_LOOP)
		##1 (upc_q == UPC_DONE))
		else $error("walk continued past the final stage");

endmodule

`default_nettype wire

### test/tb_mixed_radix_exchange_partners.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixed_radix_exchange_partners: self-checking bench for the exchange schedule
// Drives node ranks under several board sizes and stage counts. A scoreboard
// predicts every stage result (radix, partner ranks, last and truncation
// flags) and compares it field by field with what the block returns. Both
// handshakes idle at random.
// ----------------------------------------------------------------------------

module tb_mixed_radix_exchange_partners;
	import mrxp_pkg::*;

	localparam int          RANDOM_ITEMS  = 350;
	localparam int          SETTLE_CYCLES = 30;
	localparam int unsigned CYCLE_LIMIT   = 500_000;
	localparam int          MAX_BOARD     = 65536;
	localparam int          R2_TOP        = 16;
	localparam int          R3_TOP        = 10;
	localparam int          R5_TOP        = 7;
	localparam int          LVL_INTER     = 0;
	localparam int          LVL_INTRA     = 1;
	localparam longint unsigned MASK32    = 64'hFFFF_FFFF;
	localparam longint unsigned BIG_PLACE = 64'h2_0000;

	// one stage result as seen on the output channel
	typedef struct packed {
		logic [STAGE_W-1:0]     stage;
		logic [WIDTH_W-1:0]     width;
		logic [4:0][RANK_W-1:0] partners;
		logic                   final_flag;
		logic                   trunc_flag;
	} stage_result_t;

	// schedule predictor and queue of stage results still owed by the block
	class exchange_scoreboard;
		int unsigned   rpb_setting;
		int unsigned   stage_counts[2][3];
		stage_result_t pending_stages[$];
		int unsigned   errors;

		function new();
			rpb_setting = 1;
			foreach (stage_counts[l, p])
				stage_counts[l][p] = 0;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [RPB_W-1:0] data);
			case (idx)
				CFG_RANKS_PER_BOARD: rpb_setting = data;
				CFG_INTER_R2: stage_counts[LVL_INTER][PH_R2] = data[4:0];
				CFG_INTER_R3: stage_counts[LVL_INTER][PH_R3] = data[3:0];
				CFG_INTER_R5: stage_counts[LVL_INTER][PH_R5] = data[2:0];
				CFG_INTRA_R2: stage_counts[LVL_INTRA][PH_R2] = data[4:0];
				CFG_INTRA_R3: stage_counts[LVL_INTRA][PH_R3] = data[3:0];
				CFG_INTRA_R5: stage_counts[LVL_INTRA][PH_R5] = data[2:0];
				default: ;
			endcase
		endfunction

		// expand one accepted rank into its stage results
		function void note_rank(logic [RANK_W-1:0] rank);
			longint unsigned size, bidx, boff, place, grp, src, swapped, rk;
			int unsigned     total, limit, stage, level, ph, rep, p, r;
			bit              trunc, big;
			stage_result_t   res;
			size = (rpb_setting == 0) ? 1 : rpb_setting;
			bidx = rank / size;
			boff = rank % size;
			total = 0;
			foreach (stage_counts[l, q])
				total += stage_counts[l][q];
			trunc = total > MAX_STAGES;
			limit = trunc ? MAX_STAGES : total;
			if (total == 0) begin
				res = '0;
				res.final_flag = 1'b1;
				pending_stages.push_back(res);
				return;
			end
			stage = 0;
			for (level = LVL_INTER; level <= LVL_INTRA; level++) begin
				place = 1;
				big = 1'b0;
				for (ph = PH_R2; ph <= PH_R5; ph++) begin
					r = (ph == PH_R2) ? RADIX2 : (ph == PH_R3) ? RADIX3 : RADIX5;
					for (rep = 0; rep < stage_counts[level][ph]; rep++) begin
						if (stage >= limit)
							return;
						res = '0;
						res.stage = STAGE_W'(stage);
						res.width = WIDTH_W'(r);
						// partner p: same digits as the source except this stage's
						for (p = 0; p < r; p++) begin
							src = (level == LVL_INTER) ? bidx : boff;
							if (big) begin
								swapped = (p * place + src) & MASK32;
							end else begin
								grp = place * r;
								swapped = (src / grp) * grp + p * place + src % place;
							end
							if (level == LVL_INTER)
								rk = ((swapped & MASK32) * size + boff) & MASK32;
							else
								rk = (bidx * size + swapped) & MASK32;
							res.partners[p] = rk[RANK_W-1:0];
						end
						res.final_flag = (stage + 1 == limit);
						res.trunc_flag = trunc;
						pending_stages.push_back(res);
						stage++;
						place = (place * r) & MASK32;
						if (place >= BIG_PLACE)
							big = 1'b1;
					end
				end
			end
		endfunction

		function void compare_field(string name, logic [RANK_W-1:0] want,
				logic [RANK_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(stage_result_t got);
			stage_result_t want;
			if (pending_stages.size() == 0) begin
				$display("%0t: unexpected result, expected none, got stage %0d width %0d",
					$time, got.stage, got.width);
				errors++;
				return;
			end
			want = pending_stages.pop_front();
			compare_field("stage_number", want.stage, got.stage);
			compare_field("group_width", want.width, got.width);
			for (int p = 0; p < 5; p++)
				compare_field($sformatf("partner digit %0d", p), want.partners[p],
					got.partners[p]);
			compare_field("final_stage", want.final_flag, got.final_flag);
			compare_field("truncated", want.trunc_flag, got.trunc_flag);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [RANK_W-1:0]    node_rank = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STAGE_W-1:0]   stage_number;
	logic [WIDTH_W-1:0]   group_width;
	logic [RANK_W-1:0]    partner_zero, partner_one, partner_two, partner_three, partner_four;
	logic                 final_stage;
	logic                 truncated;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [RPB_W-1:0]     wr_data = '0;

	exchange_scoreboard board;
	bit                 steady = 1'b0;  // no idling on either side while set
	int unsigned        cycle_count = 0;
	int unsigned        random_sent = 0;

	mixed_radix_exchange_partners dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.node_rank    (node_rank),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.stage_number (stage_number),
		.group_width  (group_width),
		.partner_zero (partner_zero),
		.partner_one  (partner_one),
		.partner_two  (partner_two),
		.partner_three(partner_three),
		.partner_four (partner_four),
		.final_stage  (final_stage),
		.truncated    (truncated),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** mixed_radix_exchange_partners: FAILED **");
		$finish;
	end

	// result side: random stall before each transfer, then check it
	initial begin : result_sink
		int unsigned   stall;
		stage_result_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.stage      = stage_number;
			got.width      = group_width;
			got.partners   = {partner_four, partner_three, partner_two, partner_one,
				partner_zero};
			got.final_flag = final_stage;
			got.trunc_flag = truncated;
			board.check_result(got);
		end
	end

	// one rank transfer after a random gap; valid stays up if no gap follows
	task automatic send_rank(input int unsigned rank);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		node_rank <= RANK_W'(rank);
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_rank(RANK_W'(rank));
	endtask

	// hold off the sender until every owed result is in, then let the sequencer settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (board.pending_stages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RPB_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		board.write_register(idx, data);
	endtask

	task automatic write_setting(input int unsigned size,
			input int unsigned inter2, inter3, inter5, intra2, intra3, intra5);
		write_reg(CFG_RANKS_PER_BOARD, RPB_W'(size));
		write_reg(CFG_INTER_R2, RPB_W'(inter2));
		write_reg(CFG_INTER_R3, RPB_W'(inter3));
		write_reg(CFG_INTER_R5, RPB_W'(inter5));
		write_reg(CFG_INTRA_R2, RPB_W'(intra2));
		write_reg(CFG_INTRA_R3, RPB_W'(intra3));
		write_reg(CFG_INTRA_R5, RPB_W'(intra5));
		wr_en <= 1'b0;
	endtask

	// mostly a few stages per radix so many ranks finish untruncated
	function automatic int unsigned draw_count(input int unsigned top);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, top) : $urandom_range(0, 2);
	endfunction

	function automatic int unsigned draw_rank();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? {RANK_W{1'b1}} : '0;
			1: return $urandom_range(0, 255);
			default: return $urandom_range(0, MAX_BOARD - 1);
		endcase
	endfunction

	task automatic pick_random_setting();
		int unsigned size;
		int unsigned f;
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 2))
					0: size = '0;
					1: size = 1;
					default: size = MAX_BOARD;
				endcase
			end
			1: size = $urandom_range(1, 64);
			2: begin
				// board size built from the radices themselves
				size = 1;
				repeat ($urandom_range(1, 12)) begin
					case ($urandom_range(0, 2))
						0: f = RADIX2;
						1: f = RADIX3;
						default: f = RADIX5;
					endcase
					if (size * f <= MAX_BOARD)
						size = size * f;
				end
			end
			3: size = $urandom_range(0, (1 << RPB_W) - 1);
			default: size = $urandom_range(1, MAX_BOARD);
		endcase
		write_setting(size, draw_count(R2_TOP), draw_count(R3_TOP), draw_count(R5_TOP),
			draw_count(R2_TOP), draw_count(R3_TOP), draw_count(R5_TOP));
	endtask

	initial begin
		int unsigned n;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: no stages, one empty result per rank
		send_rank('0);
		send_rank({RANK_W{1'b1}});
		wait_quiet();

		// zero board size acts as one; one inter stage of each radix
		steady = 1'b1;
		write_setting('0, 1, 1, 1, 0, 0, 0);
		send_rank('0);
		send_rank({RANK_W{1'b1}});
		send_rank(16'h5555);
		send_rank(16'hAAAA);
		wait_quiet();
		steady = 1'b0;

		// one stage of every radix on both levels
		write_setting(30, 1, 1, 1, 1, 1, 1);
		send_rank(29);
		send_rank(12345);
		send_rank({RANK_W{1'b1}});
		wait_quiet();

		// every count at the bench's top value: truncated, large place values
		write_setting(MAX_BOARD, R2_TOP, R3_TOP, R5_TOP, R2_TOP, R3_TOP, R5_TOP);
		send_rank({RANK_W{1'b1}});
		send_rank('0);
		send_rank(40000);
		wait_quiet();

		// widest board size, exactly the stage limit within a board
		write_setting((1 << RPB_W) - 1, 0, 0, 0, R2_TOP, 3, 1);
		send_rank({RANK_W{1'b1}});
		send_rank(1);
		wait_quiet();

		// one stage over the limit
		write_setting(1, 0, 0, 0, R2_TOP, 5, 0);
		send_rank({RANK_W{1'b1}});
		send_rank(16'h1234);
		wait_quiet();

		// radix-5 stages only
		write_setting(2, 0, 0, R5_TOP, 0, 0, 0);
		send_rank({RANK_W{1'b1}});
		send_rank(777);
		wait_quiet();

		// counts cleared again with a nontrivial board size
		write_setting(7, 0, 0, 0, 0, 0, 0);
		send_rank(16'hBEEF);
		wait_quiet();

		// random settings, each followed by a burst of ranks
		while (random_sent < RANDOM_ITEMS) begin
			pick_random_setting();
			steady = ($urandom_range(0, 3) == 0);
			n = $urandom_range(12, 28);
			repeat (n) send_rank(draw_rank());
			random_sent += n;
			wait_quiet();
		end

		if (board.errors == 0)
			$display("** mixed_radix_exchange_partners: PASSED **");
		else
			$display("** mixed_radix_exchange_partners: FAILED **");
		$finish;
	end

endmodule
